FILE: hw/rtl/chpe_pkg.sv
// Shared types and constants for the cubic Hermite point evaluator.
package chpe_pkg;

   localparam int REG_W       = 63;   // packed x,y,z word
   localparam int NUM_REGS    = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int NUM_AXES    = 3;
   localparam int NUM_BASIS   = 4;    // weights per vector
   localparam int NUM_VECS    = 2;    // position, derivative
   localparam int RSP_TDATA_W = 128;

   // configuration register indexes, also the basis term order
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_POINT = 2'd0,
      REG_START_SLOPE = 2'd1,
      REG_END_POINT   = 2'd2,
      REG_END_SLOPE   = 2'd3
   } reg_idx_type;

   typedef logic [REG_W-1:0] vec_word_type;
   typedef vec_word_type [NUM_REGS-1:0] segment_type;

endpackage

FILE: hw/rtl/cubic_hermite_point_evaluator_core.sv
// 7 register stages: t, t^2, t^3, weights, products, axis sums, round/saturate.
// Throughput: one word per cycle while rsp_tready stays high; each stage holds
// under backpressure.
// Reset (synchronous, active high) empties the pipeline and clears the
// four segment registers to zero.
module cubic_hermite_point_evaluator_core #(
   parameter int COORD_BITS      = 21,
   parameter int PARAM_FRAC_BITS = 16,
   localparam int ReqTdataW      = ((PARAM_FRAC_BITS + 1 + 7) / 8) * 8
) (
   input  logic clock,
   input  logic reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ReqTdataW-1:0]                req_tdata,   // curve_param, zero pad
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [chpe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // position_out, derivative_out, pad
   output logic [0:0]                          rsp_tuser,   // saturated
   // configuration writes
   input  logic                                csr_wen,
   input  logic [chpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [chpe_pkg::REG_W-1:0]          csr_wdata
);

   localparam int W_W   = PARAM_FRAC_BITS + 4;
   localparam int NUM_W = chpe_pkg::NUM_VECS * chpe_pkg::NUM_BASIS;

   // segment registers: P0, M0, P1, M1
   chpe_pkg::segment_type seg_ff;

   logic                            basis_valid, basis_ready;
   logic [NUM_W-1:0][W_W-1:0]       basis_weights;
   chpe_pkg::vec_word_type          pos_word, der_word;
   logic                            sat_flag;

   // writes must arrive only while the pipeline is drained; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else if (csr_wen) begin
         unique case (chpe_pkg::reg_idx_type'(csr_index))
            chpe_pkg::REG_START_POINT: seg_ff[chpe_pkg::REG_START_POINT] <= csr_wdata;
            chpe_pkg::REG_START_SLOPE: seg_ff[chpe_pkg::REG_START_SLOPE] <= csr_wdata;
            chpe_pkg::REG_END_POINT:   seg_ff[chpe_pkg::REG_END_POINT]   <= csr_wdata;
            chpe_pkg::REG_END_SLOPE:   seg_ff[chpe_pkg::REG_END_SLOPE]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // t clamp, t^2, t^3 and the eight basis weights (4 stages)
   chpe_basis #(
      .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
   ) u_basis (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .req_param (req_tdata[PARAM_FRAC_BITS:0]),
      .out_valid (basis_valid),
      .out_ready (basis_ready),
      .weights   (basis_weights)
   );

   // weight x coordinate lanes, sums, rounding, saturation (3 stages)
   chpe_combine #(
      .COORD_BITS     (COORD_BITS),
      .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
   ) u_combine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (basis_valid),
      .in_ready   (basis_ready),
      .weights    (basis_weights),
      .segment    (seg_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .position   (pos_word),
      .derivative (der_word),
      .saturated  (sat_flag)
   );

   assign rsp_tdata = {{(chpe_pkg::RSP_TDATA_W - 2*chpe_pkg::REG_W){1'b0}}, der_word, pos_word};
   assign rsp_tuser = sat_flag;

   // an empty output stage frees the whole ready chain
   a_empty_tail_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output stage");

   // nothing comes out in the cycle right after reset
   a_reset_flush: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // pad bits above the two vectors stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[chpe_pkg::RSP_TDATA_W-1:2*chpe_pkg::REG_W] == '0)
      else $error("rsp_tdata pad bits not zero");

endmodule

FILE: hw/rtl/chpe_basis.sv
// Basis weight pipeline: clamp t, t^2, t^3, then the eight Hermite weights.
module chpe_basis #(
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [PARAM_FRAC_BITS:0]   req_param,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [chpe_pkg::NUM_VECS*chpe_pkg::NUM_BASIS-1:0][PARAM_FRAC_BITS+3:0] weights
);

   localparam int F      = PARAM_FRAC_BITS;
   localparam int T_W    = F + 1;
   localparam int EXT    = 3;
   localparam int W_W    = T_W + EXT;
   localparam int PROD_W = 2 * T_W;
   localparam int NUM_W  = chpe_pkg::NUM_VECS * chpe_pkg::NUM_BASIS;
   localparam logic [T_W-1:0]    ONE_T  = T_W'(1) << F;
   localparam logic [PROD_W-1:0] HALF_T = PROD_W'(1) << (F - 1);

   logic [3:0] v_ff, v_in, rdy;

   logic [T_W-1:0] t1_ff, t1_in;
   logic [T_W-1:0] t2_t_ff, t2_sq_ff, t2_sq_in;
   logic [T_W-1:0] t3_t_ff, t3_sq_ff, t3_cu_ff, t3_cu_in;
   logic [NUM_W-1:0][W_W-1:0] w_ff, w_in;

   logic [PROD_W-1:0] sq_full, cu_full;
   logic signed [W_W-1:0] tw, t2w, t3w, one_w;
   logic signed [W_W-1:0] t2x3, t2x6, tx2, tx4, tx6, t3x2;

   // a stage may load when it is empty or its word moves on
   assign rdy[3] = !v_ff[3] || out_ready;
   assign rdy[2] = !v_ff[2] || rdy[3];
   assign rdy[1] = !v_ff[1] || rdy[2];
   assign rdy[0] = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   assign v_in[0] = rdy[0] ? in_valid : v_ff[0];
   assign v_in[1] = rdy[1] ? v_ff[0]  : v_ff[1];
   assign v_in[2] = rdy[2] ? v_ff[1]  : v_ff[2];
   assign v_in[3] = rdy[3] ? v_ff[2]  : v_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // t above one clamps to one
   assign t1_in = (req_param > ONE_T) ? ONE_T : req_param;

   assign sq_full  = PROD_W'(t1_ff) * PROD_W'(t1_ff) + HALF_T;
   assign t2_sq_in = sq_full[F +: T_W];

   assign cu_full  = PROD_W'(t2_sq_ff) * PROD_W'(t2_t_ff) + HALF_T;
   assign t3_cu_in = cu_full[F +: T_W];

   always_comb begin
      tw    = $signed({{EXT{1'b0}}, t3_t_ff});
      t2w   = $signed({{EXT{1'b0}}, t3_sq_ff});
      t3w   = $signed({{EXT{1'b0}}, t3_cu_ff});
      one_w = $signed({{EXT{1'b0}}, ONE_T});
      t2x3  = t2w + (t2w <<< 1);
      t2x6  = t2x3 <<< 1;
      tx2   = tw <<< 1;
      tx4   = tw <<< 2;
      tx6   = tx4 + tx2;
      t3x2  = t3w <<< 1;
      // position weights h00 h10 h01 h11
      w_in[0] = t3x2 - t2x3 + one_w;
      w_in[1] = t3w - (t2w <<< 1) + tw;
      w_in[2] = t2x3 - t3x2;
      w_in[3] = t3w - t2w;
      // derivative weights
      w_in[4] = t2x6 - tx6;
      w_in[5] = t2x3 - tx4 + one_w;
      w_in[6] = tx6 - t2x6;
      w_in[7] = t2x3 - tx2;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         t1_ff <= t1_in;
      end
      if (rdy[1]) begin
         t2_t_ff  <= t1_ff;
         t2_sq_ff <= t2_sq_in;
      end
      if (rdy[2]) begin
         t3_t_ff  <= t2_t_ff;
         t3_sq_ff <= t2_sq_ff;
         t3_cu_ff <= t3_cu_in;
      end
      if (rdy[3]) begin
         w_ff <= w_in;
      end
   end

   assign out_valid = v_ff[3];
   assign weights   = w_ff;

endmodule

FILE: hw/rtl/chpe_combine.sv
// Weighted sum pipeline: products, axis sums, rounding and saturation.
module chpe_combine #(
   parameter int COORD_BITS      = 21,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [chpe_pkg::NUM_VECS*chpe_pkg::NUM_BASIS-1:0][PARAM_FRAC_BITS+3:0] weights,
   input  chpe_pkg::segment_type        segment,
   output logic                         out_valid,
   input  logic                         out_ready,
   output chpe_pkg::vec_word_type       position,
   output chpe_pkg::vec_word_type       derivative,
   output logic                         saturated
);

   localparam int C     = COORD_BITS;
   localparam int F     = PARAM_FRAC_BITS;
   localparam int W_W   = F + 4;
   localparam int P_W   = W_W + C;
   localparam int S_W   = P_W + 2;
   localparam int NV    = chpe_pkg::NUM_VECS;
   localparam int NA    = chpe_pkg::NUM_AXES;
   localparam int NB    = chpe_pkg::NUM_BASIS;
   localparam logic signed [S_W-1:0] HALF_T = S_W'(1) <<< (F - 1);

   logic [2:0] v_ff, v_in, rdy;

   logic signed [P_W-1:0] prod_ff [NV][NA][NB];
   logic signed [P_W-1:0] prod_in [NV][NA][NB];
   logic signed [S_W-1:0] sum_ff  [NV][NA];
   logic signed [S_W-1:0] sum_in  [NV][NA];
   logic signed [S_W-1:0] rnd     [NV][NA];
   logic [NV-1:0][chpe_pkg::REG_W-1:0] vec_in, vec_ff;
   logic [NV-1:0][NA-1:0] over, under;
   logic sat_in, sat_ff;

   assign rdy[2] = !v_ff[2] || out_ready;
   assign rdy[1] = !v_ff[1] || rdy[2];
   assign rdy[0] = !v_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   assign v_in[0] = rdy[0] ? in_valid : v_ff[0];
   assign v_in[1] = rdy[1] ? v_ff[0]  : v_ff[1];
   assign v_in[2] = rdy[2] ? v_ff[1]  : v_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // 24 lanes: one product per vector, axis and basis term
   always_comb begin
      for (int v = 0; v < NV; v++) begin
         for (int a = 0; a < NA; a++) begin
            for (int k = 0; k < NB; k++) begin
               prod_in[v][a][k] = $signed(weights[v*NB + k]) *
                                  $signed(segment[k][a*C +: C]);
            end
         end
      end
   end

   always_comb begin
      for (int v = 0; v < NV; v++) begin
         for (int a = 0; a < NA; a++) begin
            sum_in[v][a] = S_W'(prod_ff[v][a][0]) + S_W'(prod_ff[v][a][1]) +
                           S_W'(prod_ff[v][a][2]) + S_W'(prod_ff[v][a][3]);
         end
      end
   end

   // round half up, then clip to the signed coordinate range
   always_comb begin
      vec_in = '0;
      for (int v = 0; v < NV; v++) begin
         for (int a = 0; a < NA; a++) begin
            rnd[v][a]   = (sum_ff[v][a] + HALF_T) >>> F;
            over[v][a]  = !rnd[v][a][S_W-1] && (|rnd[v][a][S_W-2:C-1]);
            under[v][a] = rnd[v][a][S_W-1] && !(&rnd[v][a][S_W-2:C-1]);
            if (over[v][a]) begin
               vec_in[v][a*C +: C] = {1'b0, {(C-1){1'b1}}};
            end else if (under[v][a]) begin
               vec_in[v][a*C +: C] = {1'b1, {(C-1){1'b0}}};
            end else begin
               vec_in[v][a*C +: C] = rnd[v][a][C-1:0];
            end
         end
      end
      sat_in = (|over) || (|under);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prod_ff <= prod_in;
      end
      if (rdy[1]) begin
         sum_ff <= sum_in;
      end
      if (rdy[2]) begin
         vec_ff <= vec_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid  = v_ff[2];
   assign position   = vec_ff[0];
   assign derivative = vec_ff[1];
   assign saturated  = sat_ff;

endmodule

FILE: tb/cubic_hermite_point_evaluator_core_test.sv
// Self-checking testbench for the cubic Hermite point evaluator core.
module cubic_hermite_point_evaluator_core_test;

   // block geometry at its default parameters
   localparam int COORD_W   = 21;
   localparam int FRAC_W    = 16;
   localparam int PARAM_W   = FRAC_W + 1;                 // curve_param, Q1.16
   localparam int REQ_W     = ((PARAM_W + 7) / 8) * 8;    // 24-bit req word
   localparam longint T_ONE  = 64'sd1 <<< FRAC_W;
   localparam longint T_HALF = 64'sd1 <<< (FRAC_W - 1);
   localparam longint AXIS_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
   localparam longint AXIS_MIN = -(64'sd1 <<< (COORD_W - 1));
   localparam int LATENCY    = 7;      // register stages between a req word and its rsp word
   localparam int SETTLE     = LATENCY + 4;
   localparam int WATCHDOG   = 2000;   // cycles with no word moving
   localparam int PHASES     = 12;
   localparam int PHASE_WORDS = 128;

   // how a random segment is drawn
   typedef enum int {SEG_MODERATE, SEG_WIDE, SEG_EXTREME} seg_kind_type;

   // one response word, split into its fields
   typedef struct packed {
      chpe_pkg::vec_word_type position;
      chpe_pkg::vec_word_type derivative;
      logic                   saturated;
   } point_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [REQ_W-1:0]                 req_tdata  = '0;     // curve_param, zero pad
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [chpe_pkg::RSP_TDATA_W-1:0] rsp_tdata;           // position_out, derivative_out, pad
   logic [0:0]                       rsp_tuser;           // saturated
   logic                             csr_wen    = 1'b0;
   logic [chpe_pkg::CSR_IDX_W-1:0]   csr_index  = chpe_pkg::REG_START_POINT;
   logic [chpe_pkg::REG_W-1:0]       csr_wdata  = '0;

   // shadow copy of the segment registers, updated on each csr write
   chpe_pkg::segment_type shadow_segment = '0;
   point_sample_type      pending_samples[$];

   // sender/receiver pacing: eager means no idle cycles at all
   bit req_eager = 1'b0;
   bit rsp_eager = 1'b0;

   int errors          = 0;
   int words_sent      = 0;
   int samples_checked = 0;
   int samples_clipped = 0;
   int segments_loaded = 0;
   int idle_cycles     = 0;

   cubic_hermite_point_evaluator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // signed coordinate of one axis (x=0, y=1, z=2)
   function automatic longint axis_of(chpe_pkg::vec_word_type v, int axis);
      logic signed [COORD_W-1:0] c;
      c = v[axis*COORD_W +: COORD_W];
      return longint'(c);
   endfunction

   function automatic chpe_pkg::vec_word_type pack_axes(longint x, longint y, longint z);
      return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
   endfunction

   // weighted sum of the four segment vectors, per axis:
   // round half up out of Q.16, then clip to the 21-bit range
   function automatic chpe_pkg::vec_word_type blend_segment(longint w0, longint w1,
                                                            longint w2, longint w3,
                                                            inout logic clipped);
      chpe_pkg::vec_word_type packed_out;
      longint acc;
      longint r;
      packed_out = '0;
      for (int axis = 0; axis < 3; axis++) begin
         acc = w0 * axis_of(shadow_segment[chpe_pkg::REG_START_POINT], axis)
             + w1 * axis_of(shadow_segment[chpe_pkg::REG_START_SLOPE], axis)
             + w2 * axis_of(shadow_segment[chpe_pkg::REG_END_POINT], axis)
             + w3 * axis_of(shadow_segment[chpe_pkg::REG_END_SLOPE], axis);
         r = (acc + T_HALF) >>> FRAC_W;    // floor division
         if (r > AXIS_MAX) begin
            r = AXIS_MAX;
            clipped = 1'b1;
         end
         if (r < AXIS_MIN) begin
            r = AXIS_MIN;
            clipped = 1'b1;
         end
         packed_out[axis*COORD_W +: COORD_W] = r[COORD_W-1:0];
      end
      return packed_out;
   endfunction

   // position and tangent for one curve parameter
   function automatic point_sample_type hermite_sample(logic [PARAM_W-1:0] t_raw);
      point_sample_type s;
      logic   clipped;
      longint t, t2, t3;
      clipped = 1'b0;
      // t above 1.0 clamps to 1.0 without flagging
      t  = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
      t2 = (t * t + T_HALF) >>> FRAC_W;
      t3 = (t2 * t + T_HALF) >>> FRAC_W;
      s.position = blend_segment(2*t3 - 3*t2 + T_ONE, t3 - 2*t2 + t,
                                 -2*t3 + 3*t2, t3 - t2, clipped);
      s.derivative = blend_segment(6*t2 - 6*t, 3*t2 - 4*t + T_ONE,
                                   -6*t2 + 6*t, 3*t2 - 2*t, clipped);
      s.saturated = clipped;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: all sampling at the rising edge, inputs move at falling
   // ---------------------------------------------------------------------

   task automatic report_field(string name, logic [chpe_pkg::REG_W-1:0] want,
                               logic [chpe_pkg::REG_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      point_sample_type seen;
      point_sample_type want;
      if (!reset) begin
         if (csr_wen)
            shadow_segment[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) begin
            pending_samples.insert(pending_samples.size(),
                                   hermite_sample(req_tdata[PARAM_W-1:0]));
            words_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.position   = rsp_tdata[chpe_pkg::REG_W-1:0];
            seen.derivative = rsp_tdata[2*chpe_pkg::REG_W-1:chpe_pkg::REG_W];
            seen.saturated  = rsp_tuser[0];
            if (pending_samples.size() == 0) begin
               errors++;
               $display("%0t: rsp word with nothing expected, actual %h", $time, seen);
            end else begin
               want = pending_samples.pop_front();
               report_field("position", want.position, seen.position);
               report_field("derivative", want.derivative, seen.derivative);
               report_field("saturated", chpe_pkg::REG_W'(want.saturated),
                            chpe_pkg::REG_W'(seen.saturated));
               samples_checked++;
               if (want.saturated)
                  samples_clipped++;
            end
         end
      end
   end

   // watchdog: no word moving on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
         $display("%0t: timeout, %0d rsp words outstanding", $time, pending_samples.size());
         $display("cubic_hermite_point_evaluator_core: mismatch");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // receiver: random stall ahead of each rsp word, none when rsp_eager is set
   always begin : rsp_sink
      int stall;
      stall = rsp_eager ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!(rsp_tvalid && !reset));
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // one req word after a random gap; returns at the accepting edge
   task automatic send_param(input logic [PARAM_W-1:0] t_raw);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(t_raw);
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and let the pipeline run dry
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input chpe_pkg::reg_idx_type idx,
                            input chpe_pkg::vec_word_type value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // only called with the block idle
   task automatic load_segment(input chpe_pkg::vec_word_type p0,
                               input chpe_pkg::vec_word_type m0,
                               input chpe_pkg::vec_word_type p1,
                               input chpe_pkg::vec_word_type m1);
      wait_idle();
      write_reg(chpe_pkg::REG_START_POINT, p0);
      write_reg(chpe_pkg::REG_START_SLOPE, m0);
      write_reg(chpe_pkg::REG_END_POINT, p1);
      write_reg(chpe_pkg::REG_END_SLOPE, m1);
      segments_loaded++;
   endtask

   function automatic longint random_axis(seg_kind_type kind);
      case (kind)
         SEG_MODERATE: return longint'($urandom_range(0, 65535)) - 32768;
         SEG_WIDE:     return longint'($urandom_range(0, 2097151)) + AXIS_MIN;
         default: begin
            case ($urandom_range(0, 3))
               0:       return AXIS_MAX;
               1:       return AXIS_MIN;
               2:       return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   function automatic chpe_pkg::vec_word_type random_vec(seg_kind_type kind);
      return pack_axes(random_axis(kind), random_axis(kind), random_axis(kind));
   endfunction

   // mostly in-range t, with ends, clamped values and corners mixed in
   function automatic logic [PARAM_W-1:0] random_param();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         return PARAM_W'($urandom_range(0, 65536));
      else if (pick < 75)
         return PARAM_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                              : $urandom_range(65473, 65536));
      else if (pick < 88)
         return PARAM_W'($urandom_range(65537, 131071));
      else begin
         case ($urandom_range(0, 4))
            0:       return '0;
            1:       return PARAM_W'(32768);
            2:       return PARAM_W'(65535);
            3:       return PARAM_W'(65536);
            default: return '1;
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // registers come out of reset as zero: every t gives the origin
   task automatic test_reset_segment();
      send_param('0);
      send_param('1);
   endtask

   // t corners on a well-behaved segment, including the above-one clamp
   task automatic test_param_corners();
      logic [PARAM_W-1:0] corners[9];
      corners = '{'0, PARAM_W'(1), PARAM_W'(32768), PARAM_W'(65535), PARAM_W'(65536),
                  PARAM_W'(65537), PARAM_W'(21845), PARAM_W'(87381), '1};
      load_segment(pack_axes(1024, -2048, 300), pack_axes(-5000, 7000, 0),
                   pack_axes(-30000, 12345, -1), pack_axes(20000, -32768, 32767));
      foreach (corners[i])
         send_param(corners[i]);
   endtask

   // full-scale segments: equal vectors stay in range; opposite corners clip the derivative low
   task automatic test_saturation_corners();
      chpe_pkg::vec_word_type hi, lo;
      hi = pack_axes(AXIS_MAX, AXIS_MAX, AXIS_MAX);
      lo = pack_axes(AXIS_MIN, AXIS_MIN, AXIS_MIN);
      load_segment(hi, hi, hi, hi);
      send_param('0);
      send_param(PARAM_W'(32768));
      send_param(PARAM_W'(65536));
      load_segment(lo, lo, lo, lo);
      send_param('0);
      send_param(PARAM_W'(32768));
      send_param(PARAM_W'(65536));
      // opposite corners, slopes fighting each other
      load_segment(hi, lo, lo, hi);
      send_param(PARAM_W'(16384));
      send_param(PARAM_W'(49152));
      send_param('1);
   endtask

   // random segments and random t, with pacing changed per phase
   task automatic test_random_segments();
      seg_kind_type kind;
      int           pause_at;
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       kind = SEG_EXTREME;
            1, 2:    kind = SEG_WIDE;
            default: kind = SEG_MODERATE;
         endcase
         load_segment(random_vec(kind), random_vec(kind), random_vec(kind),
                      random_vec(kind));
         // three phases in four run back to back on one or both sides
         req_eager = (phase % 4 == 1) || (phase % 4 == 3);
         rsp_eager = (phase % 4 == 2) || (phase % 4 == 3);
         pause_at  = $urandom_range(1, PHASE_WORDS - 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // hold off until the pipe is empty, then resume
            if (n == pause_at)
               wait_idle();
            send_param(random_param());
         end
      end
      req_eager = 1'b0;
      rsp_eager = 1'b0;
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_reset_segment();
      test_param_corners();
      test_saturation_corners();
      test_random_segments();

      // flush, then watch a little longer for stray rsp words
      wait_idle();

      $display("%0d req words sent, %0d curve parameters checked over %0d segment settings,",
               words_sent, samples_checked, segments_loaded);
      $display("%0d of them clipped on at least one axis", samples_clipped);
      if (errors == 0)
         $display("cubic_hermite_point_evaluator_core: match");
      else
         $display("cubic_hermite_point_evaluator_core: mismatch");
      $finish;
   end

endmodule

FILE: cubic_hermite_point_evaluator_core.f
hw/rtl/chpe_pkg.sv
hw/rtl/chpe_basis.sv
hw/rtl/chpe_combine.sv
hw/rtl/cubic_hermite_point_evaluator_core.sv
tb/cubic_hermite_point_evaluator_core_test.sv
